[design/epff_pkg.sv]
package epff_pkg;

  localparam int NUM_CLASSES   = 9;
  localparam int NUM_HARMONICS = 10;
  localparam int TABLE_DEPTH   = 4 * NUM_CLASSES * NUM_HARMONICS;
  localparam int AW            = $clog2(TABLE_DEPTH);
  localparam int KW            = $clog2(NUM_HARMONICS + 1);

  // cordic datapath widths
  localparam int CORDIC_STEPS = 16;
  localparam int SW           = $clog2(CORDIC_STEPS);
  localparam int VW           = 44;
  localparam int ZW           = 20;
  localparam int FW           = 28;
  localparam int MW           = 41;

  // long division of |2p| by k, DIV_RADIX quotient bits per cycle
  localparam int DIV_BITS   = 52;
  localparam int DIV_RADIX  = 4;
  localparam int DIV_CYCLES = DIV_BITS / DIV_RADIX;

  // angles in units of 2^-16 rad, OUT_LIMIT in units of 2^-13 rad
  localparam logic signed [FW-1:0] ANG_PI      = 28'sd205887;
  localparam logic signed [FW-1:0] ANG_HALF_PI = 28'sd102944;
  localparam logic signed [FW-1:0] ANG_TWO_PI  = 28'sd411775;
  localparam logic signed [VW-1:0] ROT_START   = 44'sd652032874;
  localparam logic signed [24:0]   OUT_LIMIT   = 25'sd25736;

  typedef struct packed {
    logic               func;
    logic signed [31:0] q_even_x;
    logic signed [31:0] q_even_y;
    logic signed [31:0] q_odd_x;
    logic signed [31:0] q_odd_y;
    logic [5:0]         cent_value;
    logic               coef_plane;
    logic               coef_kind;
    logic [3:0]         coef_class;
    logic [3:0]         coef_harmonic;
    logic signed [15:0] coef_value;
  } item_t;

  typedef struct packed {
    logic [3:0]         class_index;
    logic signed [15:0] even_angle;
    logic signed [15:0] odd_angle;
  } result_t;

  typedef struct packed {
    logic          capture;
    logic          load_vec;
    logic          norm;
    logic          step;
    logic          psi;
    logic          ang;
    logic          rd_cs;
    logic          lat_sn;
    logic          lat_cs;
    logic          mul1;
    logic          mul2;
    logic          div_init;
    logic          div_step;
    logic          acc;
    logic          fin;
    logic          emit;
    logic          plane;
    logic [SW-1:0] idx;
    logic [KW-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic cls_ok;
    logic norm_done;
  } sts_t;

  function automatic logic signed [ZW-1:0] arc(input logic [SW-1:0] i);
    logic signed [ZW-1:0] a;
    unique case (i)
      4'd0:    a = 20'sd51472;
      4'd1:    a = 20'sd30386;
      4'd2:    a = 20'sd16055;
      4'd3:    a = 20'sd8150;
      4'd4:    a = 20'sd4091;
      4'd5:    a = 20'sd2047;
      4'd6:    a = 20'sd1024;
      4'd7:    a = 20'sd512;
      4'd8:    a = 20'sd256;
      4'd9:    a = 20'sd128;
      4'd10:   a = 20'sd64;
      4'd11:   a = 20'sd32;
      4'd12:   a = 20'sd16;
      4'd13:   a = 20'sd8;
      4'd14:   a = 20'sd4;
      default: a = 20'sd2;
    endcase
    return a;
  endfunction

  // floor(63*v/100) as a reciprocal multiply, exact for all 6-bit v
  function automatic logic [5:0] class_of(input logic [5:0] v);
    logic [22:0] p;
    p = 23'(v) * 23'd82593;
    return p[22:17];
  endfunction

  function automatic logic [AW-1:0] word_addr(input logic plane, input logic kind,
                                               input logic [3:0] cls, input logic [4:0] k);
    int a;
    a = ((int'(plane) * 2 + int'(kind)) * NUM_CLASSES + int'(cls)) * NUM_HARMONICS
        + int'(k) - 1;
    return AW'(a);
  endfunction

  // single wrap into [-pi, pi]
  function automatic logic signed [FW-1:0] wrap_ang(input logic signed [FW-1:0] a);
    logic signed [FW-1:0] w;
    if (a > ANG_PI) w = a - ANG_TWO_PI;
    else if (a < -ANG_PI) w = a + ANG_TWO_PI;
    else w = a;
    return w;
  endfunction

endpackage

[design/event_plane_fourier_flattening.sv]
// channel   signals                          payload
// item      item_valid / item_ready          item    (epff_pkg::item_t)
// result    result_valid / result_ready      result  (epff_pkg::result_t)
//
// a load word is taken while idle and writes the coefficient table if its
// class and harmonic are in range
// an event runs both planes through the shared cordic (16 steps for atan2,
// 16 per harmonic) and the divide by k in each harmonic
// normalization runs before atan2 in each plane
// rst is synchronous; the coefficient table is not cleared
// one event at a time; the result register lets the next word in while a
// result waits for result_ready
module event_plane_fourier_flattening (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  epff_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_ready,
  output epff_pkg::result_t   result
);

  epff_pkg::cmd_t cmd;
  epff_pkg::sts_t sts;

  // sequencer: steps both planes through atan2 and the harmonic loop
  epff_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_func    (item.func),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // table, cordic, multiplier, divider and accumulator
  epff_dp u_dp (
    .clk    (clk),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

endmodule

[design/epff_ctrl.sv]
module epff_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_func,
  output logic               item_ready,
  output logic               result_valid,
  input  logic               result_ready,
  input  epff_pkg::sts_t     sts,
  output epff_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOADV = 4'd1;
  localparam logic [3:0] S_NORM  = 4'd2;
  localparam logic [3:0] S_VEC   = 4'd3;
  localparam logic [3:0] S_PSI   = 4'd4;
  localparam logic [3:0] S_ANG   = 4'd5;
  localparam logic [3:0] S_ROT   = 4'd6;
  localparam logic [3:0] S_MUL1  = 4'd7;
  localparam logic [3:0] S_MUL2  = 4'd8;
  localparam logic [3:0] S_DINIT = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_ACC   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  localparam logic [epff_pkg::SW-1:0] LAST_STEP = epff_pkg::SW'(epff_pkg::CORDIC_STEPS - 1);
  localparam logic [epff_pkg::SW-1:0] LAST_DIV  = epff_pkg::SW'(epff_pkg::DIV_CYCLES - 1);
  localparam logic [epff_pkg::KW-1:0] LAST_K    = epff_pkg::KW'(epff_pkg::NUM_HARMONICS);

  logic [3:0]                state, state_next;
  logic [epff_pkg::SW-1:0]   step, step_next;
  logic [epff_pkg::KW-1:0]   k, k_next;
  logic                      plane, plane_next;
  logic                      result_valid_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    k_next     = k;
    plane_next = plane;
    cmd        = '0;
    cmd.plane  = plane;
    cmd.idx    = step;
    cmd.k      = k;
    result_valid_next = result_valid && !result_ready;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          if (!item_func && sts.cls_ok) begin
            plane_next = 1'b0;
            state_next = S_LOADV;
          end
        end
      end
      S_LOADV: begin
        cmd.load_vec = 1'b1;
        state_next   = S_NORM;
      end
      S_NORM: begin
        cmd.norm = 1'b1;
        if (sts.norm_done) begin
          step_next  = '0;
          state_next = S_VEC;
        end
      end
      S_VEC: begin
        cmd.step  = 1'b1;
        step_next = step + 1'b1;
        if (step == LAST_STEP) state_next = S_PSI;
      end
      S_PSI: begin
        cmd.psi    = 1'b1;
        k_next     = epff_pkg::KW'(1);
        state_next = S_ANG;
      end
      S_ANG: begin
        cmd.ang    = 1'b1;
        step_next  = '0;
        state_next = S_ROT;
      end
      S_ROT: begin
        cmd.step   = 1'b1;
        cmd.rd_cs  = (step == '0);
        cmd.lat_sn = (step == '0);
        cmd.lat_cs = (step == epff_pkg::SW'(1));
        step_next  = step + 1'b1;
        if (step == LAST_STEP) state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        step_next    = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == LAST_DIV) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (k == LAST_K) begin
          state_next = S_FIN;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_ANG;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (!plane) begin
          plane_next = 1'b1;
          state_next = S_LOADV;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!result_valid || result_ready) begin
          cmd.emit          = 1'b1;
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      k            <= '0;
      plane        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      step         <= step_next;
      k            <= k_next;
      plane        <= plane_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

[design/epff_dp.sv]
module epff_dp (
  input  logic                clk,
  input  epff_pkg::item_t     item,
  input  epff_pkg::cmd_t      cmd,
  output epff_pkg::sts_t      sts,
  output epff_pkg::result_t   result
);

  localparam int VW = epff_pkg::VW;
  localparam int ZW = epff_pkg::ZW;
  localparam int FW = epff_pkg::FW;
  localparam int MW = epff_pkg::MW;
  localparam int KW = epff_pkg::KW;
  localparam int DB = epff_pkg::DIV_BITS;

  epff_pkg::item_t item_q;
  logic [3:0]      cls_q;

  // coefficient table, single port each way
  logic signed [15:0]        mem [epff_pkg::TABLE_DEPTH];
  logic signed [15:0]        rdata;
  logic                      wr_ok;
  logic [epff_pkg::AW-1:0]   waddr, raddr;

  assign wr_ok = item.func && (int'(item.coef_class) < epff_pkg::NUM_CLASSES)
                 && (item.coef_harmonic != 4'd0)
                 && (int'(item.coef_harmonic) <= epff_pkg::NUM_HARMONICS);
  assign waddr = epff_pkg::word_addr(item.coef_plane, item.coef_kind, item.coef_class,
                                     {1'b0, item.coef_harmonic});
  assign raddr = epff_pkg::word_addr(cmd.plane, cmd.rd_cs, cls_q, 5'(cmd.k));

  always_ff @(posedge clk) begin
    if (cmd.capture && wr_ok) mem[waddr] <= item.coef_value;
    rdata <= mem[raddr];
  end

  // cordic and arithmetic state
  logic signed [VW-1:0] vx, vy;
  logic signed [ZW-1:0] vz, base, psi, r;
  logic [MW-1:0]        mag;
  logic                 zero, rotm, neg;
  logic signed [15:0]   sn, cs;
  logic signed [48:0]   m1, m2;
  logic [DB-1:0]        dv;
  logic [KW-1:0]        rem;
  logic                 dsign;
  logic signed [55:0]   acc;
  logic signed [15:0]   ang_even;
  // odd angle is kept once the second plane finishes
  logic signed [15:0]   o_sat_odd;

  assign sts.cls_ok    = int'(epff_pkg::class_of(item.cent_value)) < epff_pkg::NUM_CLASSES;
  assign sts.norm_done = zero || mag[MW-1];

  // vector load: left half-plane turned by pi
  logic signed [31:0]   qx, qy;
  logic signed [32:0]   x0, y0, xa, ya;
  logic [32:0]          ay;
  logic signed [ZW-1:0] b0;
  always_comb begin
    qx = cmd.plane ? item_q.q_odd_x : item_q.q_even_x;
    qy = cmd.plane ? item_q.q_odd_y : item_q.q_even_y;
    x0 = {qx[31], qx};
    y0 = {qy[31], qy};
    if (x0 < 0) begin
      xa = -x0;
      ya = -y0;
      b0 = (y0 >= 0) ? ZW'(epff_pkg::ANG_PI) : ZW'(-epff_pkg::ANG_PI);
    end else begin
      xa = x0;
      ya = y0;
      b0 = '0;
    end
    ay = (ya < 0) ? $unsigned(-ya) : $unsigned(ya);
  end

  // one cordic micro-rotation
  logic signed [VW-1:0] xs, ys;
  logic signed [ZW-1:0] av;
  logic                 ccw;
  always_comb begin
    xs  = vx >>> cmd.idx;
    ys  = vy >>> cmd.idx;
    av  = epff_pkg::arc(cmd.idx);
    ccw = rotm ? !vz[ZW-1] : vy[VW-1];
  end

  // harmonic angle step and fold into [-pi/2, pi/2]
  logic signed [FW-1:0] psi_w, r_w, fold;
  logic                 fneg;
  always_comb begin
    psi_w = epff_pkg::wrap_ang(FW'(base) + FW'(vz));
    r_w   = epff_pkg::wrap_ang(FW'(r) + FW'(psi));
    fneg  = 1'b1;
    if (r_w > epff_pkg::ANG_HALF_PI) fold = r_w - epff_pkg::ANG_PI;
    else if (r_w < -epff_pkg::ANG_HALF_PI) fold = r_w + epff_pkg::ANG_PI;
    else begin
      fold = r_w;
      fneg = 1'b0;
    end
  end

  logic signed [32:0] sin_v, cos_v;
  assign sin_v = neg ? -vy[32:0] : vy[32:0];
  assign cos_v = neg ? -vx[32:0] : vx[32:0];

  logic signed [50:0] p2;
  assign p2 = 51'(m1 - m2) <<< 1;

  // radix-16 restoring division step
  logic [DB-1:0]  d_n;
  logic [KW-1:0]  rem_n;
  logic [KW:0]    t;
  always_comb begin
    d_n   = dv;
    rem_n = rem;
    t     = '0;
    for (int j = 0; j < epff_pkg::DIV_RADIX; j++) begin
      t = {rem_n, d_n[DB-1]};
      if (t >= {1'b0, cmd.k}) begin
        rem_n = KW'(t - {1'b0, cmd.k});
        d_n   = {d_n[DB-2:0], 1'b1};
      end else begin
        rem_n = t[KW-1:0];
        d_n   = {d_n[DB-2:0], 1'b0};
      end
    end
  end

  logic signed [DB:0] q;
  assign q = dsign ? -$signed({1'b0, dv}) : $signed({1'b0, dv});

  // correction, final wrap, rounding to q3.13 and saturation
  logic signed [55:0]   acc_r;
  logic signed [FW-1:0] f, fw, fr;
  logic signed [24:0]   o;
  logic signed [15:0]   o_sat;
  always_comb begin
    acc_r = acc + (56'sd1 <<< 28);
    f     = FW'(psi) + FW'($signed(acc_r[55:29]));
    fw    = epff_pkg::wrap_ang(f);
    fr    = fw + 28'sd4;
    o     = fr[27:3];
    if (o > epff_pkg::OUT_LIMIT) o_sat = 16'(epff_pkg::OUT_LIMIT);
    else if (o < -epff_pkg::OUT_LIMIT) o_sat = 16'(-epff_pkg::OUT_LIMIT);
    else o_sat = o[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
      cls_q  <= 4'(epff_pkg::class_of(item.cent_value));
    end
    if (cmd.load_vec) begin
      vx   <= VW'(xa);
      vy   <= VW'(ya);
      vz   <= '0;
      base <= b0;
      mag  <= MW'((xa > $signed(ay)) ? $unsigned(xa) : ay);
      zero <= (x0 == 0) && (y0 == 0);
      rotm <= 1'b0;
    end
    if (cmd.norm && !zero && !mag[MW-1]) begin
      if (mag[MW-1:32] == '0) begin
        vx  <= vx <<< 8;
        vy  <= vy <<< 8;
        mag <= mag << 8;
      end else begin
        vx  <= vx <<< 1;
        vy  <= vy <<< 1;
        mag <= mag << 1;
      end
    end
    if (cmd.step) begin
      if (ccw) begin
        vx <= vx - ys;
        vy <= vy + xs;
        vz <= vz - av;
      end else begin
        vx <= vx + ys;
        vy <= vy - xs;
        vz <= vz + av;
      end
    end
    if (cmd.psi) begin
      psi <= zero ? '0 : ZW'(psi_w);
      r   <= '0;
      acc <= '0;
    end
    if (cmd.ang) begin
      r    <= ZW'(r_w);
      vx   <= epff_pkg::ROT_START;
      vy   <= '0;
      vz   <= ZW'(fold);
      neg  <= fneg;
      rotm <= 1'b1;
    end
    if (cmd.lat_sn) sn <= rdata;
    if (cmd.lat_cs) cs <= rdata;
    if (cmd.mul1) m1 <= cs * sin_v;
    if (cmd.mul2) m2 <= sn * cos_v;
    if (cmd.div_init) begin
      dsign <= p2[50];
      dv    <= DB'(p2[50] ? $unsigned(-p2) : $unsigned(p2));
      rem   <= '0;
    end
    if (cmd.div_step) begin
      dv  <= d_n;
      rem <= rem_n;
    end
    if (cmd.acc) acc <= acc + 56'(q);
    if (cmd.fin && !cmd.plane) ang_even <= o_sat;
    if (cmd.emit) begin
      result.class_index <= cls_q;
      result.even_angle  <= ang_even;
      result.odd_angle   <= o_sat_odd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin && cmd.plane) o_sat_odd <= o_sat;
  end

endmodule

[design/epff_chk.sv]
module epff_chk (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input epff_pkg::item_t     item,
  input logic                result_valid,
  input logic                result_ready,
  input epff_pkg::result_t   result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result dropped or changed while stalled");

  a_class: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> int'(result.class_index) < epff_pkg::NUM_CLASSES)
    else $error("class out of range");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.even_angle <= 16'sd25736 && result.even_angle >= -16'sd25736
                     && result.odd_angle <= 16'sd25736 && result.odd_angle >= -16'sd25736)
    else $error("angle beyond limit");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && !item.func
    && int'(epff_pkg::class_of(item.cent_value)) < epff_pkg::NUM_CLASSES |=> !item_ready)
    else $error("event accepted without going busy");

endmodule

bind event_plane_fourier_flattening epff_chk u_chk (.*);
